>>> hdl/egd_pkg.sv
// Shared types, codes and block pattern tables for the Exp-Golomb bit decoder.
package egd_pkg;

    // Element kinds carried on the cmd field.
    localparam logic [2:0] CMD_U  = 3'd0;
    localparam logic [2:0] CMD_UE = 3'd1;
    localparam logic [2:0] CMD_SE = 3'd2;
    localparam logic [2:0] CMD_TE = 3'd3;
    localparam logic [2:0] CMD_ME = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_CODE    = 2'd1;
    localparam logic [1:0] ST_LONG_PREFIX = 2'd2;

    // Largest code numbers that the pattern tables cover.
    localparam logic [32:0] BIG_LAST   = 33'd47;
    localparam logic [32:0] SMALL_LAST = 33'd15;

    // Chroma array types that select the large tables.
    localparam logic [1:0] CAT_420 = 2'd1;
    localparam logic [1:0] CAT_422 = 2'd2;

    // Mapping applied to a finished code number.
    typedef enum logic [1:0] {
        OP_PASS,
        OP_SE,
        OP_ME
    } op_t;

    // Finished element handed from the bit decoder to the value mapper.
    typedef struct packed {
        op_t         op;
        logic        intra;
        logic [32:0] code;
        logic [5:0]  bits_used;
        logic [1:0]  status;
    } egd_elem_t;

    // Coded block pattern tables, indexed by code number.
    localparam logic [5:0] BIG_INTRA [48] = '{
        6'd47, 6'd31, 6'd15, 6'd0,  6'd23, 6'd27, 6'd29, 6'd30,
        6'd7,  6'd11, 6'd13, 6'd14, 6'd39, 6'd43, 6'd45, 6'd46,
        6'd16, 6'd3,  6'd5,  6'd10, 6'd12, 6'd19, 6'd21, 6'd26,
        6'd28, 6'd35, 6'd37, 6'd42, 6'd44, 6'd1,  6'd2,  6'd4,
        6'd8,  6'd17, 6'd18, 6'd20, 6'd24, 6'd6,  6'd9,  6'd22,
        6'd25, 6'd32, 6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41
    };
    localparam logic [5:0] BIG_INTER [48] = '{
        6'd0,  6'd16, 6'd1,  6'd2,  6'd4,  6'd8,  6'd32, 6'd3,
        6'd5,  6'd10, 6'd12, 6'd15, 6'd47, 6'd7,  6'd11, 6'd13,
        6'd14, 6'd6,  6'd9,  6'd31, 6'd35, 6'd37, 6'd42, 6'd44,
        6'd33, 6'd34, 6'd36, 6'd40, 6'd38, 6'd41, 6'd43, 6'd45,
        6'd46, 6'd17, 6'd18, 6'd20, 6'd24, 6'd19, 6'd21, 6'd26,
        6'd28, 6'd23, 6'd27, 6'd29, 6'd30, 6'd22, 6'd25, 6'd39
    };
    localparam logic [3:0] SMALL_INTRA [16] = '{
        4'd15, 4'd0, 4'd7, 4'd11, 4'd13, 4'd14, 4'd3, 4'd5,
        4'd10, 4'd12, 4'd1, 4'd2, 4'd4, 4'd8, 4'd6, 4'd9
    };
    localparam logic [3:0] SMALL_INTER [16] = '{
        4'd0, 4'd1, 4'd2, 4'd4, 4'd8, 4'd3, 4'd5, 4'd10,
        4'd12, 4'd15, 4'd7, 4'd11, 4'd13, 4'd14, 4'd6, 4'd9
    };

endpackage

>>> hdl/egd_if.sv
// Channel interfaces: bit input, result output and configuration write.
interface egd_in_if;
    logic       valid;
    logic       ready;
    logic       bit_req;
    logic [2:0] cmd;
    logic [5:0] fixed_length;
    logic       te_single_bit;
    logic       is_intra;

    modport source (output valid, bit_req, cmd, fixed_length, te_single_bit, is_intra,
                    input ready);
    modport sink (input valid, bit_req, cmd, fixed_length, te_single_bit, is_intra,
                  output ready);
endinterface

interface egd_out_if;
    logic               valid;
    logic               ready;
    logic signed [32:0] value;
    logic [5:0]         bits_used;
    logic [1:0]         status;

    modport source (output valid, value, bits_used, status, input ready);
    modport sink (input valid, value, bits_used, status, output ready);
endinterface

interface egd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] chroma_array_type;

    modport source (output valid, chroma_array_type, input ready);
    modport sink (input valid, chroma_array_type, output ready);
endinterface

>>> hdl/egd_bit_fsm.sv
// Per-bit element decoder: prefix, suffix and fixed-length state with a result stage.
module egd_bit_fsm #(
    parameter int MAX_PREFIX_ZEROS = 31
) (
    input  logic              clk,
    input  logic              rst_n,
    egd_in_if.sink            stream,
    output egd_pkg::egd_elem_t elem,
    output logic              elem_valid,
    input  logic              elem_ready
);
    import egd_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_PREFIX = 4'b0010,
        PH_SUFFIX = 4'b0100,
        PH_FIXED  = 4'b1000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [5:0]  zc_reg, zc_next;
    logic [31:0] acc_reg, acc_next;
    logic [5:0]  left_reg, left_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic        intra_reg, intra_next;
    logic [5:0]  total_reg, total_next;

    egd_elem_t   elem_reg, res;
    logic        elem_valid_reg;
    logic        emit;
    logic        take;
    op_t         fin_op;

    // A bit is taken whenever the result stage can move on.
    assign stream.ready = !elem_valid_reg || elem_ready;
    assign take = stream.valid && stream.ready;

    // Mapping that a finished code number gets.
    always_comb
    begin
        case (cmd_next)
            CMD_SE:  fin_op = OP_SE;
            CMD_ME:  fin_op = OP_ME;
            default: fin_op = OP_PASS;
        endcase
    end

    // Next state and finished element for the offered bit.
    always_comb
    begin
        phase_next = phase_reg;
        zc_next    = zc_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        cmd_next   = cmd_reg;
        intra_next = intra_reg;
        total_next = total_reg;
        emit       = 1'b0;
        res        = '{op: OP_PASS, intra: intra_reg, code: 33'd0,
                       bits_used: 6'd0, status: ST_OK};

        if (phase_reg == PH_IDLE)
        begin
            cmd_next   = stream.cmd;
            intra_next = stream.is_intra;
            total_next = 6'd0;
            zc_next    = 6'd0;
            acc_next   = 32'd0;
            if (stream.cmd == CMD_U)
            begin
                if (stream.fixed_length == 6'd0)
                    left_next = 6'd1;
                else if (stream.fixed_length > 6'd32)
                    left_next = 6'd32;
                else
                    left_next = stream.fixed_length;
                phase_next = PH_FIXED;
            end
            else if (stream.cmd == CMD_TE && stream.te_single_bit)
            begin
                // Range of one: a single inverted bit.
                total_next = 6'd1;
                emit       = 1'b1;
                res.code   = {32'd0, ~stream.bit_req};
            end
            else
            begin
                phase_next = PH_PREFIX;
            end
        end

        res.intra = intra_next;

        if (!emit)
        begin
            total_next = total_next + 6'd1;
            case (phase_next)
                PH_FIXED:
                begin
                    acc_next  = {acc_next[30:0], stream.bit_req};
                    left_next = left_next - 6'd1;
                    if (left_next == 6'd0)
                    begin
                        emit       = 1'b1;
                        res.code   = {1'b0, acc_next};
                        phase_next = PH_IDLE;
                    end
                end
                PH_PREFIX:
                begin
                    if (!stream.bit_req)
                    begin
                        zc_next = zc_next + 6'd1;
                        if (zc_next > 6'(MAX_PREFIX_ZEROS))
                        begin
                            emit       = 1'b1;
                            res.status = ST_LONG_PREFIX;
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (zc_next == 6'd0)
                    begin
                        emit       = 1'b1;
                        res.op     = fin_op;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        left_next  = zc_next;
                        acc_next   = 32'd0;
                        phase_next = PH_SUFFIX;
                    end
                end
                PH_SUFFIX:
                begin
                    acc_next  = {acc_next[30:0], stream.bit_req};
                    left_next = left_next - 6'd1;
                    if (left_next == 6'd0)
                    begin
                        emit       = 1'b1;
                        res.op     = fin_op;
                        res.code   = ((33'd1 << zc_next[4:0]) - 33'd1) + {1'b0, acc_next};
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        res.bits_used = total_next;
    end

    // Running element state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            zc_reg    <= 6'd0;
            acc_reg   <= 32'd0;
            left_reg  <= 6'd0;
            cmd_reg   <= CMD_U;
            intra_reg <= 1'b0;
            total_reg <= 6'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            zc_reg    <= zc_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            cmd_reg   <= cmd_next;
            intra_reg <= intra_next;
            total_reg <= total_next;
        end
    end

    // Result stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            elem_valid_reg <= 1'b0;
        else if (stream.ready)
            elem_valid_reg <= take && emit;
    end

    // Result stage payload.
    always_ff @(posedge clk)
    begin
        if (take && emit)
            elem_reg <= res;
    end

    assign elem       = elem_reg;
    assign elem_valid = elem_valid_reg;

endmodule

>>> hdl/egd_map.sv
// Value mapper: signed mapping and block pattern lookup into the output register.
module egd_map (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         chroma_array_type,
    input  egd_pkg::egd_elem_t elem,
    input  logic               elem_valid,
    output logic               elem_ready,
    egd_out_if.source          result
);
    import egd_pkg::*;

    logic        out_valid_reg;
    logic [32:0] value_reg, value_next;
    logic [5:0]  bits_reg;
    logic [1:0]  status_reg, status_next;
    logic        big;

    assign elem_ready = !out_valid_reg || result.ready;
    assign big = (chroma_array_type == CAT_420) || (chroma_array_type == CAT_422);

    // Map the code number to the element value.
    always_comb
    begin
        value_next  = 33'd0;
        status_next = elem.status;
        case (elem.op)
            OP_PASS:
                value_next = elem.code;
            OP_SE:
            begin
                if (elem.code[0])
                    value_next = (elem.code + 33'd1) >> 1;
                else
                    value_next = 33'd0 - {1'b0, elem.code[32:1]};
            end
            OP_ME:
            begin
                if (big)
                begin
                    if (elem.code > BIG_LAST)
                        status_next = ST_BAD_CODE;
                    else if (elem.intra)
                        value_next = {27'd0, BIG_INTRA[elem.code[5:0]]};
                    else
                        value_next = {27'd0, BIG_INTER[elem.code[5:0]]};
                end
                else
                begin
                    if (elem.code > SMALL_LAST)
                        status_next = ST_BAD_CODE;
                    else if (elem.intra)
                        value_next = {29'd0, SMALL_INTRA[elem.code[3:0]]};
                    else
                        value_next = {29'd0, SMALL_INTER[elem.code[3:0]]};
                end
            end
            default:
                value_next = elem.code;
        endcase
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (elem_ready)
            out_valid_reg <= elem_valid;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (elem_ready && elem_valid)
        begin
            value_reg  <= value_next;
            bits_reg   <= elem.bits_used;
            status_reg <= status_next;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.value     = $signed(value_reg);
    assign result.bits_used = bits_reg;
    assign result.status    = status_reg;

endmodule

>>> hdl/exp_golomb_bit_decoder_unit.sv
// Top level of the Exp-Golomb bit decoder: config register and the two stages.
//
// The stream channel takes one bitstream bit per item, most significant first.
// The cmd, fixed_length, te_single_bit and is_intra fields are sampled only on
// the first bit of a syntax element and ignored on the bits that follow.
// When the bit that ends an element is taken, one item appears on the result
// channel with the value, the bit count of the element and a status.
// The edge that takes the last bit of an element loads the bit decoder's result
// stage, and the mapper's output register loads from that stage once it is
// free, so the result is registered in both stages. One bit is taken per
// cycle while the result channel does not stall both stages; the per-bit
// state update and the code-number add are combinational.
// The cfg channel writes chroma_array_type; it is always ready and should be
// written only between elements with no result pending.
// Reset clears the element state to idle, empties both stages and sets
// chroma_array_type to 1. A stall on the result channel backs up through the
// two stages and drops stream.ready only once both hold an item.
module exp_golomb_bit_decoder_unit #(
    parameter int MAX_PREFIX_ZEROS = 31
) (
    input  logic      clk,
    input  logic      rst_n,
    egd_in_if.sink    stream,
    egd_out_if.source result,
    egd_cfg_if.sink   cfg
);
    import egd_pkg::*;

    logic [1:0] chroma_reg;
    egd_elem_t  elem;
    logic       elem_valid;
    logic       elem_ready;

    // Chroma array type register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            chroma_reg <= CAT_420;
        else if (cfg.valid)
            chroma_reg <= cfg.chroma_array_type;
    end

    // Bit decoder stage.
    egd_bit_fsm #(
        .MAX_PREFIX_ZEROS (MAX_PREFIX_ZEROS)
    ) u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .elem       (elem),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready)
    );

    // Value mapping stage.
    egd_map u_map (
        .clk               (clk),
        .rst_n             (rst_n),
        .chroma_array_type (chroma_reg),
        .elem              (elem),
        .elem_valid        (elem_valid),
        .elem_ready        (elem_ready),
        .result            (result)
    );

endmodule

>>> bench/exp_golomb_bit_decoder_unit_tb.sv
// Self-checking testbench for the Exp-Golomb bit decoder with a bit-level decode predictor.
`timescale 1ns / 1ps

module exp_golomb_bit_decoder_unit_tb;
    import egd_pkg::*;

    localparam int MAX_ZEROS   = 31;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 6;
    localparam int PHASE_BITS  = 208;

    // One bitstream bit with the element fields that ride along with it.
    typedef struct packed {
        logic       bit_req;
        logic [2:0] cmd;
        logic [5:0] fixed_length;
        logic       te_single_bit;
        logic       is_intra;
    } stream_item_t;

    // One decoded syntax element.
    typedef struct packed {
        logic [32:0] value;
        logic [5:0]  bits_used;
        logic [1:0]  status;
    } elem_result_t;

    // Parser position within a syntax element.
    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_PREFIX,
        PARSE_SUFFIX,
        PARSE_FIXED
    } parse_t;

    logic clk;
    logic rst_n;

    egd_in_if  stream_ch ();
    egd_out_if result_ch ();
    egd_cfg_if cfg_ch ();

    exp_golomb_bit_decoder_unit #(
        .MAX_PREFIX_ZEROS(MAX_ZEROS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(stream_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    // Decoder state as the predictor tracks it.
    parse_t      parse       = PARSE_IDLE;
    logic [5:0]  zeros       = '0;
    logic [31:0] accum       = '0;
    logic [5:0]  left        = '0;
    logic [2:0]  held_kind   = CMD_U;
    logic        held_intra  = 1'b0;
    logic [5:0]  total       = '0;
    logic [1:0]  chroma_sel  = CAT_420;

    stream_item_t bit_queue[$];
    elem_result_t pending_results[$];

    stream_item_t cur_bit;
    logic         busy       = 1'b0;
    int           in_gap     = 0;
    int           out_stall  = 0;
    logic         quiet      = 1'b0;
    int           bits_queued = 0;
    int           bits_taken  = 0;
    int           mismatches  = 0;
    int           cycles      = 0;

    logic [1:0] chroma_plan [6] = '{2'd0, 2'd3, 2'd2, 2'd1, 2'd0, 2'd2};

    // Maps a finished code number according to the held element kind.
    function automatic logic map_code(input logic [32:0] code, output elem_result_t r);
        logic [32:0] v;
        logic [1:0]  st;
        st = ST_OK;
        v  = code;
        if (held_kind == CMD_SE) begin
            if (code[0])
                v = (code + 33'd1) >> 1;
            else
                v = 33'd0 - (code >> 1);
        end else if (held_kind == CMD_ME) begin
            if (chroma_sel == CAT_420 || chroma_sel == CAT_422) begin
                if (code > BIG_LAST) begin
                    v  = '0;
                    st = ST_BAD_CODE;
                end else begin
                    v = held_intra ? {27'd0, BIG_INTRA[code[5:0]]}
                                   : {27'd0, BIG_INTER[code[5:0]]};
                end
            end else begin
                if (code > SMALL_LAST) begin
                    v  = '0;
                    st = ST_BAD_CODE;
                end else begin
                    v = held_intra ? {29'd0, SMALL_INTRA[code[3:0]]}
                                   : {29'd0, SMALL_INTER[code[3:0]]};
                end
            end
        end
        r.value     = v;
        r.bits_used = total;
        r.status    = st;
        parse       = PARSE_IDLE;
        return 1'b1;
    endfunction

    // Advances the decoder by one bit; returns 1 when an element completes.
    function automatic logic decode_bit(input stream_item_t it, output elem_result_t r);
        logic [5:0]  len;
        logic [32:0] code;
        r = '0;
        if (parse == PARSE_IDLE) begin
            len        = it.fixed_length;
            held_kind  = it.cmd;
            held_intra = it.is_intra;
            total      = '0;
            zeros      = '0;
            accum      = '0;
            if (held_kind == CMD_U) begin
                if (len == 6'd0)
                    len = 6'd1;
                if (len > 6'd32)
                    len = 6'd32;
                left  = len;
                parse = PARSE_FIXED;
            end else if (held_kind == CMD_TE && it.te_single_bit) begin
                r.value     = {32'd0, ~it.bit_req};
                r.bits_used = 6'd1;
                r.status    = ST_OK;
                return 1'b1;
            end else begin
                parse = PARSE_PREFIX;
            end
        end

        total = total + 6'd1;

        case (parse)
            PARSE_FIXED:
            begin
                accum = {accum[30:0], it.bit_req};
                left  = left - 6'd1;
                if (left == 6'd0)
                begin
                    r.value     = {1'b0, accum};
                    r.bits_used = total;
                    r.status    = ST_OK;
                    parse       = PARSE_IDLE;
                    return 1'b1;
                end
                return 1'b0;
            end
            PARSE_PREFIX:
            begin
                if (!it.bit_req) begin
                    zeros = zeros + 6'd1;
                    if (zeros > MAX_ZEROS)
                    begin
                        r.value     = '0;
                        r.bits_used = total;
                        r.status    = ST_LONG_PREFIX;
                        parse       = PARSE_IDLE;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (zeros == 6'd0)
                    return map_code(33'd0, r);
                left  = zeros;
                accum = '0;
                parse = PARSE_SUFFIX;
                return 1'b0;
            end
            default:
            begin
                accum = {accum[30:0], it.bit_req};
                left  = left - 6'd1;
                if (left == 6'd0)
                begin
                    code = ((33'd1 << zeros[4:0]) - 33'd1) + {1'b0, accum};
                    return map_code(code, r);
                end
                return 1'b0;
            end
        endcase
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int hold_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Queues one bit; bits after the first of an element carry random fields.
    task automatic queue_bit(input logic b, input logic lead, input stream_item_t head);
        stream_item_t it;
        if (lead)
        begin
            it = head;
        end else begin
            it.cmd           = 3'($urandom_range(0, 7));
            it.fixed_length  = 6'($urandom_range(0, 63));
            it.te_single_bit = 1'($urandom_range(0, 1));
            it.is_intra      = 1'($urandom_range(0, 1));
        end
        it.bit_req = b;
        bit_queue.push_back(it);
        bits_queued++;
    endtask

    // Queues a whole well-formed element; zc above the limit gives a too-long prefix.
    task automatic queue_element(input logic [2:0] kind, input logic [5:0] len,
                                 input logic te, input logic intra, input int zc,
                                 input logic [31:0] payload);
        stream_item_t head;
        int           n;
        head = '{bit_req: 1'b0, cmd: kind, fixed_length: len,
                 te_single_bit: te, is_intra: intra};
        if (kind == CMD_U)
        begin
            n = (len == 6'd0) ? 1 : (len > 6'd32) ? 32 : int'(len);
            for (int i = n - 1; i >= 0; i--)
                queue_bit(payload[i], i == n - 1, head);
        end else if (kind == CMD_TE && te) begin
            queue_bit(payload[0], 1'b1, head);
        end else if (zc > MAX_ZEROS) begin
            for (int i = 0; i <= MAX_ZEROS; i++)
                queue_bit(1'b0, i == 0, head);
        end else begin
            for (int i = 0; i < zc; i++)
                queue_bit(1'b0, i == 0, head);
            queue_bit(1'b1, zc == 0, head);
            for (int i = zc - 1; i >= 0; i--)
                queue_bit(payload[i], 1'b0, head);
        end
    endtask

    // Random element: all kinds including unused codes, mostly short prefixes.
    task automatic queue_random_element();
        int         r;
        int         zc;
        logic [5:0] len;
        r = $urandom_range(0, 99);
        if (r < 70)
            len = 6'($urandom_range(1, 8));
        else if (r < 90)
            len = 6'($urandom_range(9, 32));
        else
            len = 6'($urandom_range(0, 63));
        r = $urandom_range(0, 99);
        if (r < 40)
            zc = $urandom_range(0, 2);
        else if (r < 75)
            zc = $urandom_range(3, 6);
        else if (r < 95)
            zc = $urandom_range(7, MAX_ZEROS);
        else
            zc = MAX_ZEROS + 1;
        queue_element(3'($urandom_range(0, 7)), len, 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), zc, $urandom);
    endtask

    // Waits until every queued bit is taken and every result has arrived.
    task automatic wait_drain();
        while (bits_taken != bits_queued || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Writes the chroma array type while the decoder is idle.
    task automatic write_chroma(input logic [1:0] cat);
        @(posedge clk);
        cfg_ch.valid             <= 1'b1;
        cfg_ch.chroma_array_type <= cat;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bit driver; predicts each result at the edge that takes its bit.
    always @(posedge clk)
    begin
        elem_result_t res;
        if (!rst_n)
        begin
            stream_ch.valid         <= 1'b0;
            stream_ch.bit_req       <= 1'b0;
            stream_ch.cmd           <= CMD_U;
            stream_ch.fixed_length  <= '0;
            stream_ch.te_single_bit <= 1'b0;
            stream_ch.is_intra      <= 1'b0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready)
                chroma_sel = cfg_ch.chroma_array_type;
            if (stream_ch.valid && stream_ch.ready)
            begin
                if (decode_bit(cur_bit, res))
                    pending_results.push_back(res);
                bits_taken++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                end else if (bit_queue.size() != 0) begin
                    cur_bit = bit_queue.pop_front();
                    busy    = 1'b1;
                    in_gap  = quiet ? 0 : hold_cycles();
                end
            end
            stream_ch.valid         <= busy;
            stream_ch.bit_req       <= cur_bit.bit_req;
            stream_ch.cmd           <= cur_bit.cmd;
            stream_ch.fixed_length  <= cur_bit.fixed_length;
            stream_ch.te_single_bit <= cur_bit.te_single_bit;
            stream_ch.is_intra      <= cur_bit.is_intra;
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge clk)
    begin
        elem_result_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result item value %0d bits_used %0d status %0d",
                             $time, result_ch.value, result_ch.bits_used, result_ch.status);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (result_ch.value !== want.value)
                    begin
                        $display("%0t: value expected %0d, got %0d",
                                 $time, $signed(want.value), result_ch.value);
                        mismatches++;
                    end
                    if (result_ch.bits_used !== want.bits_used)
                    begin
                        $display("%0t: bits_used expected %0d, got %0d",
                                 $time, want.bits_used, result_ch.bits_used);
                        mismatches++;
                    end
                    if (result_ch.status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, want.status, result_ch.status);
                        mismatches++;
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    out_stall = hold_cycles();
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n                     <= 1'b0;
        cfg_ch.valid              <= 1'b0;
        cfg_ch.chroma_array_type  <= '0;
        cur_bit                   = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed elements under the reset chroma type: zero fixed length,
        // single-bit te both ways, short ue/se/me codes and unused commands.
        queue_element(CMD_U,  6'd0, 1'b0, 1'b0, 0, 32'd1);
        queue_element(CMD_TE, 6'd5, 1'b1, 1'b0, 0, 32'd0);
        queue_element(CMD_TE, 6'd5, 1'b1, 1'b1, 0, 32'd1);
        queue_element(CMD_UE, 6'd3, 1'b0, 1'b0, 0, 32'd0);
        queue_element(CMD_SE, 6'd9, 1'b0, 1'b0, 1, 32'd0);
        queue_element(CMD_SE, 6'd9, 1'b1, 1'b1, 1, 32'd1);
        queue_element(CMD_ME, 6'd1, 1'b0, 1'b1, 2, 32'd3);
        queue_element(CMD_ME, 6'd1, 1'b1, 1'b0, 0, 32'd0);
        queue_element(3'd7,   6'd63, 1'b1, 1'b1, 0, 32'd0);
        queue_element(3'd5,   6'd0, 1'b0, 1'b0, 1, 32'd1);
        queue_element(CMD_TE, 6'd2, 1'b0, 1'b0, 1, 32'd0);
        queue_element(CMD_U,  6'd2, 1'b0, 1'b1, 0, 32'd3);
        wait_drain();

        for (int p = 0; p < 6; p++)
        begin
            write_chroma(chroma_plan[p]);
            quiet = (p == 1 || p == 4);
            if (p == 0)
            begin
                // Value extremes, long fixed length, bad pattern code, long prefix.
                queue_element(CMD_UE, 6'd0, 1'b0, 1'b0, MAX_ZEROS, 32'hFFFF_FFFF);
                queue_element(CMD_SE, 6'd0, 1'b0, 1'b0, MAX_ZEROS, 32'hFFFF_FFFF);
                queue_element(CMD_SE, 6'd0, 1'b0, 1'b0, MAX_ZEROS, 32'h7FFF_FFFE);
                queue_element(CMD_U,  6'd63, 1'b0, 1'b0, 0, 32'hFFFF_FFFF);
                queue_element(CMD_U,  6'd32, 1'b0, 1'b0, 0, 32'h8000_0001);
                queue_element(CMD_ME, 6'd0, 1'b0, 1'b1, 5, 32'd31);
                queue_element(CMD_UE, 6'd0, 1'b0, 1'b0, MAX_ZEROS + 1, 32'd0);
            end
            while (bits_queued < (p + 1) * PHASE_BITS + 200)
                queue_random_element();
            wait_drain();
        end

        if (mismatches == 0 && pending_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
